### rtl/core/segment_constraint_bellman_ford_search_assert.svh
// Assertion macros used by the checker file of this block.
`ifndef SEGMENT_CONSTRAINT_BELLMAN_FORD_SEARCH_ASSERT_SVH
`define SEGMENT_CONSTRAINT_BELLMAN_FORD_SEARCH_ASSERT_SVH

// Property checked at every rising clock edge outside of reset.
`define SCBF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("scbf assertion failed");

// Condition that must never be seen outside of reset.
`define SCBF_ASSERT_NEVER(lbl, clk, rst_n, cond) \
  `SCBF_ASSERT(lbl, clk, rst_n, !(cond))

`endif

### rtl/core/scbf_pkg.sv
package scbf_pkg;

  localparam int DIST_W  = 32;
  localparam int FIELD_W = 20;
  localparam int CFG_W   = 16;
  localparam int APB_AW  = 3;
  localparam int APB_DW  = 32;

  localparam logic [CFG_W-1:0] SEARCH_LOW_RST  = 16'd1;
  localparam logic [CFG_W-1:0] SEARCH_HIGH_RST = 16'd401;

  // Register index, taken from the word address bit of paddr.
  localparam logic REG_SEARCH_LOW  = 1'b0;
  localparam logic REG_SEARCH_HIGH = 1'b1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_SOLVE = 1'b1;

  typedef logic signed [DIST_W-1:0] dist_t;

  typedef struct packed {
    logic               cmd;
    logic [FIELD_W-1:0] seg_start;
    logic [FIELD_W-1:0] seg_end;
  } item_t;

  typedef struct packed {
    logic             found;
    logic [CFG_W-1:0] min_weight;
  } result_t;

endpackage

### rtl/core/scbf_ram.sv
module scbf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/core/segment_constraint_bellman_ford_search.sv
// Segment constraint search. A command with cmd low stores one segment
// [seg_start, seg_end) and gives no result; busy stays low, so loads may
// follow back to back, and loads beyond MAX_SEGMENTS are dropped.
// A command with cmd high solves: busy rises, and the block sorts the segment
// endpoints into node memory, maps each segment to its two node indices, then
// binary-searches the weight between search_low and search_high, running
// Bellman-Ford for each candidate. Exactly one result is shown on result_o for
// the single cycle in which result_valid_o is high, at the same edge busy
// falls. The receiver cannot stall it, so it must take the transfer in that
// cycle. A solve with C segments and N (at most 2C) distinct nodes runs the
// insertion sort, the duplicate sweep and the node lookup, then up to 17
// weight probes, each a clearing of the N node distances followed by up to
// N+1 Bellman-Ford passes. Every step is paced by the single read port of
// the node memory, which holds first the sorted coordinates and then the
// distances. The solve also empties the segment store.
module segment_constraint_bellman_ford_search #(
  parameter int MAX_SEGMENTS = 512,
  parameter int COORD_BITS   = 20
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Command channel.
  input  logic                                  start,
  output logic                                  busy,
  input  scbf_pkg::item_t                       item_i,
  // Result channel.
  output logic                                  result_valid_o,
  output scbf_pkg::result_t                     result_o,
  // Configuration port.
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [scbf_pkg::APB_AW-1:0]           paddr,
  input  logic [scbf_pkg::APB_DW-1:0]           pwdata,
  output logic [scbf_pkg::APB_DW-1:0]           prdata,
  output logic                                  pready
);

  localparam int DistW   = scbf_pkg::DIST_W;
  localparam int CfgW    = scbf_pkg::CFG_W;
  localparam int KeepW   = (COORD_BITS < scbf_pkg::FIELD_W) ? COORD_BITS : scbf_pkg::FIELD_W;
  localparam int SegAW   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int SegCW   = $clog2(MAX_SEGMENTS + 1);
  localparam int NodeAW  = $clog2(2 * MAX_SEGMENTS);
  localparam int NodeCW  = NodeAW + 1;
  localparam int PassW   = NodeCW + 1;
  localparam int SegW    = (2 * COORD_BITS > 2 * NodeAW) ? 2 * COORD_BITS : 2 * NodeAW;
  localparam int SrchW   = CfgW + 2;

  // One-hot sequencer states.
  typedef enum logic [22:0] {
    ST_IDLE       = 23'h000001,
    ST_SORT_SEG   = 23'h000002,
    ST_SORT_LD    = 23'h000004,
    ST_INS_CHK    = 23'h000008,
    ST_INS_CMP    = 23'h000010,
    ST_DD_RD      = 23'h000020,
    ST_DD_CMP     = 23'h000040,
    ST_MAP_SEG    = 23'h000080,
    ST_MAP_LD     = 23'h000100,
    ST_BS_CHK     = 23'h000200,
    ST_BS_CMP     = 23'h000400,
    ST_P_START    = 23'h000800,
    ST_INIT       = 23'h001000,
    ST_PASS_START = 23'h002000,
    ST_CH_RD      = 23'h004000,
    ST_CH_UPD     = 23'h008000,
    ST_SG_RD      = 23'h010000,
    ST_SG_LD      = 23'h020000,
    ST_SG_A       = 23'h040000,
    ST_SG_B       = 23'h080000,
    ST_SG_W       = 23'h100000,
    ST_PASS_END   = 23'h200000,
    ST_RESULT     = 23'h400000
  } state_e;

  state_e state_q, state_d;

  logic [CfgW-1:0]     low_q, low_d, high_q, high_d;
  logic [SegCW-1:0]    cnt_q, cnt_d, si_q, si_d;
  logic                half_q, half_d;
  scbf_pkg::dist_t     v_q, v_d, vb_q, vb_d, last_q, last_d;
  scbf_pkg::dist_t     cur_q, cur_d, da_q, da_d, db_q, db_d;
  logic [NodeCW-1:0]   j_q, j_d, k_q, k_d, ci_q, ci_d, w_q, w_d, n_q, n_d;
  logic [NodeCW-1:0]   lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [NodeAW-1:0]   na_q, na_d, a_q, a_d, b_q, b_d;
  logic [SrchW-1:0]    l_q, l_d, r_q, r_d;
  logic [CfgW-1:0]     p_q, p_d, best_q, best_d;
  logic [PassW-1:0]    pass_q, pass_d;
  logic                chg_q, chg_d, found_q, found_d;
  logic                res_valid_q, res_valid_d;
  scbf_pkg::result_t   res_q, res_d;

  // Memory ports.
  logic                seg_we;
  logic [SegAW-1:0]    seg_waddr, seg_raddr;
  logic [SegW-1:0]     seg_wdata, seg_rdata;
  logic                nd_we;
  logic [NodeAW-1:0]   nd_waddr, nd_raddr;
  logic [DistW-1:0]    nd_wdata, nd_rdata;

  logic                    cmd_accept, cfg_write, ins_fin;
  logic [COORD_BITS-1:0]   ld_start, ld_end, rd_start, rd_end;
  scbf_pkg::dist_t         key_lo, key_hi, nd_rd, p_ext, cand_b, cand_a;
  logic [NodeCW:0]         bs_sum;
  logic [NodeCW-1:0]       bs_mid, jm1;
  logic signed [SrchW:0]   lr_sum;

  scbf_ram #(.WIDTH(SegW), .DEPTH(MAX_SEGMENTS)) u_seg_ram (
    .clk_i  (clk_i),
    .we_i   (seg_we),
    .waddr_i(seg_waddr),
    .wdata_i(seg_wdata),
    .raddr_i(seg_raddr),
    .rdata_o(seg_rdata)
  );

  // Node memory: sorted coordinates while building the graph, distances after.
  scbf_ram #(.WIDTH(DistW), .DEPTH(2 * MAX_SEGMENTS)) u_node_ram (
    .clk_i  (clk_i),
    .we_i   (nd_we),
    .waddr_i(nd_waddr),
    .wdata_i(nd_wdata),
    .raddr_i(nd_raddr),
    .rdata_o(nd_rdata)
  );

  assign busy       = (state_q != ST_IDLE);
  assign cmd_accept = start && (state_q == ST_IDLE);
  assign cfg_write  = psel && penable && pwrite;
  assign pready     = 1'b1;

  always_comb begin
    prdata = '0;
    case (paddr[2])
      scbf_pkg::REG_SEARCH_LOW:  prdata = scbf_pkg::APB_DW'(low_q);
      scbf_pkg::REG_SEARCH_HIGH: prdata = scbf_pkg::APB_DW'(high_q);
      default:                   prdata = '0;
    endcase
  end

  // Coordinates are masked to COORD_BITS when stored.
  assign ld_start = COORD_BITS'(item_i.seg_start[KeepW-1:0]);
  assign ld_end   = COORD_BITS'(item_i.seg_end[KeepW-1:0]);
  assign rd_start = seg_rdata[COORD_BITS-1:0];
  assign rd_end   = seg_rdata[2*COORD_BITS-1:COORD_BITS];

  // Start endpoint 2*s, end endpoint 2*e-1 (an end of zero gives -1).
  assign key_lo = scbf_pkg::dist_t'({1'b0, rd_start, 1'b0});
  assign key_hi = scbf_pkg::dist_t'({1'b0, rd_end, 1'b0}) - scbf_pkg::dist_t'(1);

  assign nd_rd  = scbf_pkg::dist_t'(nd_rdata);
  assign p_ext  = scbf_pkg::dist_t'(p_q);
  assign cand_b = da_q + p_ext;
  assign cand_a = db_q - scbf_pkg::dist_t'(1);
  assign bs_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign bs_mid = bs_sum[NodeCW:1];
  assign jm1    = j_q - NodeCW'(1);
  assign lr_sum = {l_q[SrchW-1], l_q} + {r_q[SrchW-1], r_q};

  // An insertion finishes when it reaches the bottom or meets a key that is not larger.
  assign ins_fin = ((state_q == ST_INS_CHK) && (j_q == '0)) ||
                   ((state_q == ST_INS_CMP) && !(nd_rd > v_q));

  always_comb begin
    state_d     = state_q;
    low_d       = low_q;
    high_d      = high_q;
    cnt_d       = cnt_q;
    si_d        = si_q;
    half_d      = half_q;
    v_d         = v_q;
    vb_d        = vb_q;
    last_d      = last_q;
    cur_d       = cur_q;
    da_d        = da_q;
    db_d        = db_q;
    j_d         = j_q;
    k_d         = k_q;
    ci_d        = ci_q;
    w_d         = w_q;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    na_d        = na_q;
    a_d         = a_q;
    b_d         = b_q;
    l_d         = l_q;
    r_d         = r_q;
    p_d         = p_q;
    best_d      = best_q;
    pass_d      = pass_q;
    chg_d       = chg_q;
    found_d     = found_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    seg_we    = 1'b0;
    seg_waddr = si_q[SegAW-1:0];
    seg_wdata = SegW'({ld_end, ld_start});
    seg_raddr = si_q[SegAW-1:0];
    nd_we     = 1'b0;
    nd_waddr  = j_q[NodeAW-1:0];
    nd_wdata  = v_q;
    nd_raddr  = jm1[NodeAW-1:0];

    if (cfg_write) begin
      case (paddr[2])
        scbf_pkg::REG_SEARCH_LOW:  low_d  = pwdata[CfgW-1:0];
        scbf_pkg::REG_SEARCH_HIGH: high_d = pwdata[CfgW-1:0];
        default: ;
      endcase
    end

    case (state_q)
      ST_IDLE: begin
        if (cmd_accept) begin
          if (item_i.cmd == scbf_pkg::CMD_SOLVE) begin
            found_d = 1'b0;
            best_d  = '0;
            k_d     = '0;
            si_d    = '0;
            n_d     = '0;
            l_d     = SrchW'(low_q);
            r_d     = SrchW'(high_q);
            state_d = (cnt_q == '0) ? ST_P_START : ST_SORT_SEG;
          end else if (cnt_q < SegCW'(MAX_SEGMENTS)) begin
            seg_we    = 1'b1;
            seg_waddr = cnt_q[SegAW-1:0];
            cnt_d     = cnt_q + SegCW'(1);
          end
        end
      end
      ST_SORT_SEG: state_d = ST_SORT_LD;
      ST_SORT_LD: begin
        v_d     = key_lo;
        vb_d    = key_hi;
        half_d  = 1'b0;
        j_d     = k_q;
        state_d = ST_INS_CHK;
      end
      ST_INS_CHK: begin
        if (j_q == '0) begin
          nd_we    = 1'b1;
          nd_waddr = '0;
        end else begin
          state_d = ST_INS_CMP;
        end
      end
      ST_INS_CMP: begin
        nd_we = 1'b1;
        if (nd_rd > v_q) begin
          // Shift the larger key up by one slot.
          nd_wdata = nd_rd;
          j_d      = jm1;
          state_d  = ST_INS_CHK;
        end
      end
      ST_DD_RD: begin
        nd_raddr = ci_q[NodeAW-1:0];
        state_d  = ST_DD_CMP;
      end
      ST_DD_CMP: begin
        nd_waddr = w_q[NodeAW-1:0];
        nd_wdata = nd_rd;
        if ((ci_q == '0) || (nd_rd != last_q)) begin
          nd_we  = 1'b1;
          w_d    = w_q + NodeCW'(1);
          last_d = nd_rd;
        end
        ci_d = ci_q + NodeCW'(1);
        if (ci_q + NodeCW'(1) == k_q) begin
          n_d     = w_d;
          si_d    = '0;
          state_d = ST_MAP_SEG;
        end else begin
          state_d = ST_DD_RD;
        end
      end
      ST_MAP_SEG: state_d = ST_MAP_LD;
      ST_MAP_LD: begin
        v_d     = key_lo;
        vb_d    = key_hi;
        half_d  = 1'b0;
        lo_d    = '0;
        hi_d    = n_q;
        state_d = ST_BS_CHK;
      end
      ST_BS_CHK: begin
        if (lo_q < hi_q) begin
          nd_raddr = bs_mid[NodeAW-1:0];
          mid_d    = bs_mid;
          state_d  = ST_BS_CMP;
        end else if (!half_q) begin
          na_d   = lo_q[NodeAW-1:0];
          half_d = 1'b1;
          v_d    = vb_q;
          lo_d   = '0;
          hi_d   = n_q;
        end else begin
          // Replace the raw coordinates with the two node indices.
          seg_we    = 1'b1;
          seg_wdata = SegW'({lo_q[NodeAW-1:0], na_q});
          si_d      = si_q + SegCW'(1);
          state_d   = (si_q + SegCW'(1) == cnt_q) ? ST_P_START : ST_MAP_SEG;
        end
      end
      ST_BS_CMP: begin
        if (nd_rd < v_q) begin
          lo_d = mid_q + NodeCW'(1);
        end else begin
          hi_d = mid_q;
        end
        state_d = ST_BS_CHK;
      end
      ST_P_START: begin
        if ($signed(l_q) <= $signed(r_q)) begin
          p_d     = lr_sum[CfgW:1];
          ci_d    = '0;
          state_d = ST_INIT;
        end else begin
          state_d = ST_RESULT;
        end
      end
      ST_INIT: begin
        // The source edges leave every node at distance zero.
        if (ci_q < n_q) begin
          nd_we    = 1'b1;
          nd_waddr = ci_q[NodeAW-1:0];
          nd_wdata = '0;
          ci_d     = ci_q + NodeCW'(1);
        end else begin
          pass_d  = '0;
          state_d = ST_PASS_START;
        end
      end
      ST_PASS_START: begin
        chg_d  = 1'b0;
        pass_d = pass_q + PassW'(1);
        if (n_q != '0) begin
          ci_d    = n_q - NodeCW'(1);
          state_d = ST_CH_RD;
        end else begin
          state_d = ST_PASS_END;
        end
      end
      ST_CH_RD: begin
        nd_raddr = ci_q[NodeAW-1:0];
        state_d  = ST_CH_UPD;
      end
      ST_CH_UPD: begin
        // Zero-weight edges from each node to its lower neighbor, walked
        // downward with the running value held in cur.
        nd_waddr = ci_q[NodeAW-1:0];
        nd_wdata = cur_q;
        if (ci_q == n_q - NodeCW'(1)) begin
          cur_d = nd_rd;
        end else if (nd_rd > cur_q) begin
          nd_we = 1'b1;
          chg_d = 1'b1;
        end else begin
          cur_d = nd_rd;
        end
        if (ci_q == '0) begin
          si_d    = '0;
          state_d = ST_SG_RD;
        end else begin
          ci_d    = ci_q - NodeCW'(1);
          state_d = ST_CH_RD;
        end
      end
      ST_SG_RD: state_d = ST_SG_LD;
      ST_SG_LD: begin
        a_d      = seg_rdata[NodeAW-1:0];
        b_d      = seg_rdata[2*NodeAW-1:NodeAW];
        nd_raddr = seg_rdata[NodeAW-1:0];
        state_d  = ST_SG_A;
      end
      ST_SG_A: begin
        da_d     = nd_rd;
        nd_raddr = b_q;
        state_d  = ST_SG_B;
      end
      ST_SG_B: begin
        // Start-to-end edge of weight p.
        nd_waddr = b_q;
        nd_wdata = cand_b;
        if (cand_b < nd_rd) begin
          nd_we = 1'b1;
          chg_d = 1'b1;
          db_d  = cand_b;
        end else begin
          db_d = nd_rd;
        end
        state_d = ST_SG_W;
      end
      ST_SG_W: begin
        // End-to-start edge of weight -1, using the updated end distance.
        nd_waddr = a_q;
        nd_wdata = cand_a;
        if (cand_a < da_q) begin
          nd_we = 1'b1;
          chg_d = 1'b1;
        end
        si_d    = si_q + SegCW'(1);
        state_d = (si_q + SegCW'(1) == cnt_q) ? ST_PASS_END : ST_SG_RD;
      end
      ST_PASS_END: begin
        if (!chg_q) begin
          // Converged: no negative cycle, so p is feasible.
          found_d = 1'b1;
          best_d  = p_q;
          r_d     = SrchW'(p_q) - SrchW'(1);
          state_d = ST_P_START;
        end else if (pass_q == ({1'b0, n_q} + PassW'(1))) begin
          l_d     = SrchW'(p_q) + SrchW'(1);
          state_d = ST_P_START;
        end else begin
          state_d = ST_PASS_START;
        end
      end
      ST_RESULT: begin
        res_valid_d      = 1'b1;
        res_d.found      = found_q;
        res_d.min_weight = found_q ? best_q : '0;
        cnt_d            = '0;
        state_d          = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase

    if (ins_fin) begin
      nd_wdata = v_q;
      k_d      = k_q + NodeCW'(1);
      if (!half_q) begin
        half_d  = 1'b1;
        v_d     = vb_q;
        j_d     = k_q + NodeCW'(1);
        state_d = ST_INS_CHK;
      end else begin
        si_d = si_q + SegCW'(1);
        if (si_q + SegCW'(1) == cnt_q) begin
          ci_d    = '0;
          w_d     = '0;
          state_d = ST_DD_RD;
        end else begin
          state_d = ST_SORT_SEG;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      low_q       <= scbf_pkg::SEARCH_LOW_RST;
      high_q      <= scbf_pkg::SEARCH_HIGH_RST;
      cnt_q       <= '0;
      si_q        <= '0;
      half_q      <= 1'b0;
      j_q         <= '0;
      k_q         <= '0;
      ci_q        <= '0;
      w_q         <= '0;
      n_q         <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      l_q         <= '0;
      r_q         <= '0;
      pass_q      <= '0;
      chg_q       <= 1'b0;
      found_q     <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      low_q       <= low_d;
      high_q      <= high_d;
      cnt_q       <= cnt_d;
      si_q        <= si_d;
      half_q      <= half_d;
      j_q         <= j_d;
      k_q         <= k_d;
      ci_q        <= ci_d;
      w_q         <= w_d;
      n_q         <= n_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      l_q         <= l_d;
      r_q         <= r_d;
      pass_q      <= pass_d;
      chg_q       <= chg_d;
      found_q     <= found_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q    <= v_d;
    vb_q   <= vb_d;
    last_q <= last_d;
    cur_q  <= cur_d;
    da_q   <= da_d;
    db_q   <= db_d;
    mid_q  <= mid_d;
    na_q   <= na_d;
    a_q    <= a_d;
    b_q    <= b_d;
    p_q    <= p_d;
    best_q <= best_d;
    res_q  <= res_d;
  end

  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

endmodule

### rtl/core/scbf_checker.sv
`include "segment_constraint_bellman_ford_search_assert.svh"

module scbf_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input scbf_pkg::result_t result_o
);

  // A result closes a solve that was running in the cycle before.
  `SCBF_ASSERT(a_result_ends_solve, clk_i, rst_ni, result_valid_o |-> $past(busy))
  // Busy only rises on a command transfer.
  `SCBF_ASSERT(a_busy_from_start, clk_i, rst_ni, $rose(busy) |-> $past(start))
  // Every solve ends in exactly one result.
  `SCBF_ASSERT(a_busy_fall_result, clk_i, rst_ni, $fell(busy) |-> result_valid_o)
  `SCBF_ASSERT(a_absent_zero, clk_i, rst_ni,
    (result_valid_o && !result_o.found) |-> (result_o.min_weight == '0))
  `SCBF_ASSERT_NEVER(a_result_while_busy, clk_i, rst_ni, result_valid_o && busy)

endmodule

bind segment_constraint_bellman_ford_search scbf_checker u_scbf_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .start         (start),
  .busy          (busy),
  .result_valid_o(result_valid_o),
  .result_o      (result_o)
);
